// ===== hdl/ppq_pkg.sv =====
// ============================================================================
// ppq_pkg
// Shared constants for the quadratic proximity penalty pipeline: field
// widths, internal fixed-point formats, register indexes and stage latencies.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ppq_pkg;

  // Input positions, signed fixed point
  localparam int POS_W      = 24;
  localparam int POS_FRAC   = 12;
  // Internal magnitudes carry 20 fraction bits
  localparam int INNER_FRAC = 20;
  localparam int THR_FRAC   = 12;
  localparam int POS_SHIFT  = INNER_FRAC - POS_FRAC;
  localparam int THR_SHIFT  = INNER_FRAC - THR_FRAC;
  // Offset magnitude bits (in input format) below the far limit
  localparam int OFF_W      = 11 + POS_FRAC;
  localparam int SQ_W       = 2 * OFF_W;
  localparam int DIST_W     = 11 + INNER_FRAC;

  // Configuration registers
  localparam int THR_W      = 23;
  localparam int WGT_W      = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd1;
  localparam logic [THR_W-1:0] THR_RESET = 23'd4096;
  localparam logic [WGT_W-1:0] WGT_RESET = 24'd65536;

  // Result fields
  localparam int COST_W     = 39;
  localparam int OUT_W      = 40;

  // Product widths
  localparam int WD_W       = WGT_W + DIST_W;
  localparam int HP_W       = WD_W + SQ_W;
  localparam int GRAD_P_W   = WD_W + OFF_W;
  localparam int COST_P_W   = WD_W + DIST_W;
  localparam int COST_SHIFT = 2 * INNER_FRAC + 1;
  localparam int CW_W       = WGT_W + THR_W;
  localparam int HXY_P_W    = CW_W + SQ_W;
  localparam int HESS_SHIFT = 2 * POS_SHIFT;
  localparam int HXY_SHIFT  = THR_SHIFT + 2 * POS_SHIFT;
  localparam int D2_W       = 2 * DIST_W;
  localparam int D3_W       = 3 * DIST_W;

  // Pipelined multiplier: 64 x 64 from four 32 x 32 partial products
  localparam int OP_W       = 64;
  localparam int HALF_W     = OP_W / 2;
  localparam int PROD_W     = 2 * OP_W;
  localparam int MUL_LAT    = 3;

  // Pipelined integer square root
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_DPS   = 4;
  localparam int SQRT_LAT   = ROOT_W / SQRT_DPS;

  // Pipelined restoring divider with a limited quotient
  localparam int NUM_W      = HP_W + HESS_SHIFT;
  localparam int DEN_W      = D3_W;
  localparam int QUO_W      = OUT_W;
  localparam int DIV_LAT    = QUO_W + 1;

endpackage

`default_nettype wire

// ===== hdl/proximity_penalty_quadratic_unit.sv =====
// ============================================================================
// proximity_penalty_quadratic_unit
// Quadratic proximity penalty of two planar positions with gradient and
// Hessian terms, as a fully pipelined datapath.
// ============================================================================
// A new item may be started in every clock cycle while busy is low. busy is a
// registered flag that is set during reset and cleared by the first clock edge
// without reset, and it stays low after that. Each item's result is strobed on
// out_valid for one cycle. Results come out in the order the items came in.
// The 61 register stages are the offset, square and compare stages (3), the
// square root (8 stages of 4 bits), the distance stage (1), two chained
// pipelined multipliers (3 each), the operand stage (1), the 40-bit restoring
// dividers (41) and the output register (1). There is no back-pressure on the
// result side, so a result must be taken in the cycle it is shown. Register
// writes must land while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module proximity_penalty_quadratic_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Item input
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [ppq_pkg::POS_W-1:0]      in_first_x,
  input  wire logic signed [ppq_pkg::POS_W-1:0]      in_first_y,
  input  wire logic signed [ppq_pkg::POS_W-1:0]      in_second_x,
  input  wire logic signed [ppq_pkg::POS_W-1:0]      in_second_y,
  // Configuration writes
  input  wire logic                                  cfg_we,
  input  wire logic        [ppq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [ppq_pkg::CFG_W-1:0]      cfg_data,
  // Results
  output logic                                       out_valid,
  output logic                                       out_active,
  output logic                                       out_degenerate,
  output logic             [ppq_pkg::COST_W-1:0]     out_cost,
  output logic signed      [ppq_pkg::OUT_W-1:0]      out_grad_x,
  output logic signed      [ppq_pkg::OUT_W-1:0]      out_grad_y,
  output logic signed      [ppq_pkg::OUT_W-1:0]      out_hess_xx,
  output logic signed      [ppq_pkg::OUT_W-1:0]      out_hess_yy,
  output logic signed      [ppq_pkg::OUT_W-1:0]      out_hess_xy
);

  localparam int POS_W      = ppq_pkg::POS_W;
  localparam int OFF_W      = ppq_pkg::OFF_W;
  localparam int SQ_W       = ppq_pkg::SQ_W;
  localparam int DIST_W     = ppq_pkg::DIST_W;
  localparam int THR_W      = ppq_pkg::THR_W;
  localparam int WGT_W      = ppq_pkg::WGT_W;
  localparam int CW_W       = ppq_pkg::CW_W;
  localparam int COST_W     = ppq_pkg::COST_W;
  localparam int OUT_W      = ppq_pkg::OUT_W;
  localparam int WD_W       = ppq_pkg::WD_W;
  localparam int HP_W       = ppq_pkg::HP_W;
  localparam int GRAD_P_W   = ppq_pkg::GRAD_P_W;
  localparam int COST_P_W   = ppq_pkg::COST_P_W;
  localparam int COST_SHIFT = ppq_pkg::COST_SHIFT;
  localparam int HXY_P_W    = ppq_pkg::HXY_P_W;
  localparam int HESS_SHIFT = ppq_pkg::HESS_SHIFT;
  localparam int HXY_SHIFT  = ppq_pkg::HXY_SHIFT;
  localparam int POS_SHIFT  = ppq_pkg::POS_SHIFT;
  localparam int THR_SHIFT  = ppq_pkg::THR_SHIFT;
  localparam int INNER_FRAC = ppq_pkg::INNER_FRAC;
  localparam int D2_W       = ppq_pkg::D2_W;
  localparam int D3_W       = ppq_pkg::D3_W;
  localparam int OP_W       = ppq_pkg::OP_W;
  localparam int PROD_W     = ppq_pkg::PROD_W;
  localparam int MUL_LAT    = ppq_pkg::MUL_LAT;
  localparam int RAD_W      = ppq_pkg::RAD_W;
  localparam int ROOT_W     = ppq_pkg::ROOT_W;
  localparam int SQRT_LAT   = ppq_pkg::SQRT_LAT;
  localparam int NUM_W      = ppq_pkg::NUM_W;
  localparam int DEN_W      = ppq_pkg::DEN_W;
  localparam int QUO_W      = ppq_pkg::QUO_W;
  localparam int DIV_LAT    = ppq_pkg::DIV_LAT;

  // Per-item data that rides along the front half of the pipeline
  typedef struct packed {
    logic              valid;
    logic              far;
    logic              act;
    logic              zero;
    logic              nx;
    logic              ny;
    logic [OFF_W-1:0]  adx;
    logic [OFF_W-1:0]  ady;
    logic [SQ_W-1:0]   adx2;
    logic [SQ_W-1:0]   ady2;
    logic [SQ_W-1:0]   axy;
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] g;
  } side_t;

  // Per-item flags that ride alongside the dividers
  typedef struct packed {
    logic              valid;
    logic              act;
    logic              zero;
    logic              nx;
    logic              ny;
    logic              hxx_neg;
    logic              hyy_neg;
    logic [COST_W-1:0] cost;
  } post_t;

  // --------------------------------------------------------------------------
  // Configuration registers and values derived from them
  // --------------------------------------------------------------------------
  logic [THR_W-1:0]   thr_r;
  logic [WGT_W-1:0]   wgt_r;
  logic [2*THR_W-1:0] thr2_r;
  logic [CW_W-1:0]    cw_r;
  logic               busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ppq_pkg::THR_RESET;
      wgt_r <= ppq_pkg::WGT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppq_pkg::REG_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
        ppq_pkg::REG_WEIGHT:    wgt_r <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr2_r <= thr_r * thr_r;
    cw_r   <= wgt_r * thr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // --------------------------------------------------------------------------
  // Stage 0: offsets as sign and magnitude, far check
  // --------------------------------------------------------------------------
  logic              in_take;
  logic signed [POS_W:0] dfx, dfy;
  logic [POS_W:0]    abx, aby;
  side_t             s0_nxt, s0_r;

  assign in_take = start && !busy_r;
  assign dfx = {in_first_x[POS_W-1], in_first_x} - {in_second_x[POS_W-1], in_second_x};
  assign dfy = {in_first_y[POS_W-1], in_first_y} - {in_second_y[POS_W-1], in_second_y};
  assign abx = dfx[POS_W] ? (POS_W+1)'(-dfx) : dfx;
  assign aby = dfy[POS_W] ? (POS_W+1)'(-dfy) : dfy;

  always_comb begin
    s0_nxt       = '0;
    s0_nxt.valid = in_take;
    s0_nxt.nx    = dfx[POS_W];
    s0_nxt.ny    = dfy[POS_W];
    s0_nxt.far   = (|abx[POS_W:OFF_W]) || (|aby[POS_W:OFF_W]);
    s0_nxt.adx   = abx[OFF_W-1:0];
    s0_nxt.ady   = aby[OFF_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage 1: squares and cross product of the offsets
  // --------------------------------------------------------------------------
  side_t s1_nxt, s1_r;

  always_comb begin
    s1_nxt      = s0_r;
    s1_nxt.adx2 = s0_r.adx * s0_r.adx;
    s1_nxt.ady2 = s0_r.ady * s0_r.ady;
    s1_nxt.axy  = s0_r.adx * s0_r.ady;
  end

  // --------------------------------------------------------------------------
  // Stage 2: squared distance, compare against squared threshold
  // --------------------------------------------------------------------------
  side_t           s2_nxt, s2_r;
  logic [SQ_W:0]   sum_sq;
  logic [RAD_W-1:0] rad_nxt, rad_r;

  assign sum_sq  = {1'b0, s1_r.adx2} + {1'b0, s1_r.ady2};
  assign rad_nxt = RAD_W'({sum_sq, {(2*POS_SHIFT){1'b0}}});

  always_comb begin
    s2_nxt      = s1_r;
    s2_nxt.act  = !s1_r.far && (sum_sq < (SQ_W+1)'(thr2_r));
    s2_nxt.zero = (sum_sq == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
  end

  // --------------------------------------------------------------------------
  // Square root of the squared distance
  // --------------------------------------------------------------------------
  logic [ROOT_W-1:0] root;
  side_t             sq_side_r [SQRT_LAT];

  ppq_sqrt u_sqrt (
    .clk     (clk),
    .sq_rad  (rad_r),
    .sq_root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_LAT; i++) begin
        sq_side_r[i] <= '0;
      end
    end else begin
      sq_side_r[0] <= s2_r;
      for (int i = 1; i < SQRT_LAT; i++) begin
        sq_side_r[i] <= sq_side_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: distance and gap to the threshold
  // --------------------------------------------------------------------------
  side_t            s3_nxt, s3_r;
  logic [DIST_W-1:0] tq;

  assign tq = DIST_W'({thr_r, {THR_SHIFT{1'b0}}});

  always_comb begin
    s3_nxt   = sq_side_r[SQRT_LAT-1];
    s3_nxt.d = root[DIST_W-1:0];
    s3_nxt.g = tq - root[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else begin
      s3_r <= s3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // First products: w*d, w*g, d*d
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] p_wd, p_wg, p_d2;
  side_t             m1_side_r [MUL_LAT];
  side_t             m1;

  ppq_mul u_mul_wd (.clk(clk), .mul_a(OP_W'(wgt_r)), .mul_b(OP_W'(s3_r.d)), .mul_p(p_wd));
  ppq_mul u_mul_wg (.clk(clk), .mul_a(OP_W'(wgt_r)), .mul_b(OP_W'(s3_r.g)), .mul_p(p_wg));
  ppq_mul u_mul_d2 (.clk(clk), .mul_a(OP_W'(s3_r.d)), .mul_b(OP_W'(s3_r.d)), .mul_p(p_d2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MUL_LAT; i++) begin
        m1_side_r[i] <= '0;
      end
    end else begin
      m1_side_r[0] <= s3_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        m1_side_r[i] <= m1_side_r[i-1];
      end
    end
  end

  assign m1 = m1_side_r[MUL_LAT-1];

  // --------------------------------------------------------------------------
  // Second products: Hessian terms, gradient numerators, cost, d cubed
  // --------------------------------------------------------------------------
  logic [OP_W-1:0]   op_wd, op_wg, op_d2;
  logic [PROD_W-1:0] p_axx, p_bxx, p_ayy, p_byy, p_hxy, p_gx, p_gy, p_cst, p_d3;
  side_t             m2_side_r [MUL_LAT];
  side_t             m2;

  assign op_wd = OP_W'(p_wd[WD_W-1:0]);
  assign op_wg = OP_W'(p_wg[WD_W-1:0]);
  assign op_d2 = OP_W'(p_d2[D2_W-1:0]);

  ppq_mul u_mul_axx (.clk(clk), .mul_a(op_wd), .mul_b(OP_W'(m1.adx2)), .mul_p(p_axx));
  ppq_mul u_mul_bxx (.clk(clk), .mul_a(op_wg), .mul_b(OP_W'(m1.ady2)), .mul_p(p_bxx));
  ppq_mul u_mul_ayy (.clk(clk), .mul_a(op_wd), .mul_b(OP_W'(m1.ady2)), .mul_p(p_ayy));
  ppq_mul u_mul_byy (.clk(clk), .mul_a(op_wg), .mul_b(OP_W'(m1.adx2)), .mul_p(p_byy));
  ppq_mul u_mul_hxy (.clk(clk), .mul_a(OP_W'(cw_r)), .mul_b(OP_W'(m1.axy)), .mul_p(p_hxy));
  ppq_mul u_mul_gx  (.clk(clk), .mul_a(op_wg), .mul_b(OP_W'(m1.adx)), .mul_p(p_gx));
  ppq_mul u_mul_gy  (.clk(clk), .mul_a(op_wg), .mul_b(OP_W'(m1.ady)), .mul_p(p_gy));
  ppq_mul u_mul_cst (.clk(clk), .mul_a(op_wg), .mul_b(OP_W'(m1.g)), .mul_p(p_cst));
  ppq_mul u_mul_d3  (.clk(clk), .mul_a(op_d2), .mul_b(OP_W'(m1.d)), .mul_p(p_d3));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MUL_LAT; i++) begin
        m2_side_r[i] <= '0;
      end
    end else begin
      m2_side_r[0] <= m1;
      for (int i = 1; i < MUL_LAT; i++) begin
        m2_side_r[i] <= m2_side_r[i-1];
      end
    end
  end

  assign m2 = m2_side_r[MUL_LAT-1];

  // --------------------------------------------------------------------------
  // Stage 4: Hessian differences, cost scaling, divider operands
  // --------------------------------------------------------------------------
  logic [HP_W:0]       dxx_ab, dxx_ba, dyy_ab, dyy_ba;
  logic [HP_W-1:0]     mag_xx, mag_yy;
  logic [COST_P_W-1:0] cst;
  post_t               s4_nxt, s4_r;
  logic [NUM_W-1:0]    gx_num_r, gy_num_r, hxx_num_r, hyy_num_r, hxy_num_r;
  logic [DEN_W-1:0]    dg_r, d3_r;

  assign dxx_ab = {1'b0, p_axx[HP_W-1:0]} - {1'b0, p_bxx[HP_W-1:0]};
  assign dxx_ba = {1'b0, p_bxx[HP_W-1:0]} - {1'b0, p_axx[HP_W-1:0]};
  assign dyy_ab = {1'b0, p_ayy[HP_W-1:0]} - {1'b0, p_byy[HP_W-1:0]};
  assign dyy_ba = {1'b0, p_byy[HP_W-1:0]} - {1'b0, p_ayy[HP_W-1:0]};
  assign mag_xx = dxx_ab[HP_W] ? dxx_ba[HP_W-1:0] : dxx_ab[HP_W-1:0];
  assign mag_yy = dyy_ab[HP_W] ? dyy_ba[HP_W-1:0] : dyy_ab[HP_W-1:0];
  assign cst    = p_cst[COST_P_W-1:0];

  always_comb begin
    s4_nxt.valid   = m2.valid;
    s4_nxt.act     = m2.act;
    s4_nxt.zero    = m2.zero;
    s4_nxt.nx      = m2.nx;
    s4_nxt.ny      = m2.ny;
    s4_nxt.hxx_neg = dxx_ab[HP_W];
    s4_nxt.hyy_neg = dyy_ab[HP_W];
    // Cost saturates at the top of its field
    if (|cst[COST_P_W-1:COST_SHIFT+COST_W]) begin
      s4_nxt.cost = '1;
    end else begin
      s4_nxt.cost = cst[COST_SHIFT+COST_W-1:COST_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r <= '0;
    end else begin
      s4_r <= s4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gx_num_r  <= NUM_W'({p_gx[GRAD_P_W-1:0], {POS_SHIFT{1'b0}}});
    gy_num_r  <= NUM_W'({p_gy[GRAD_P_W-1:0], {POS_SHIFT{1'b0}}});
    hxx_num_r <= NUM_W'({mag_xx, {HESS_SHIFT{1'b0}}});
    hyy_num_r <= NUM_W'({mag_yy, {HESS_SHIFT{1'b0}}});
    hxy_num_r <= NUM_W'({p_hxy[HXY_P_W-1:0], {HXY_SHIFT{1'b0}}});
    dg_r      <= DEN_W'({m2.d, {INNER_FRAC{1'b0}}});
    d3_r      <= DEN_W'(p_d3[D3_W-1:0]);
  end

  // --------------------------------------------------------------------------
  // Dividers
  // --------------------------------------------------------------------------
  logic [QUO_W-1:0] q_gx, q_gy, q_hxx, q_hyy, q_hxy;
  logic             o_gx, o_gy, o_hxx, o_hyy, o_hxy;
  post_t            dv_side_r [DIV_LAT];

  ppq_div u_div_gx  (.clk(clk), .div_num(gx_num_r),  .div_den(dg_r),
                     .div_quo(q_gx),  .div_ovf(o_gx));
  ppq_div u_div_gy  (.clk(clk), .div_num(gy_num_r),  .div_den(dg_r),
                     .div_quo(q_gy),  .div_ovf(o_gy));
  ppq_div u_div_hxx (.clk(clk), .div_num(hxx_num_r), .div_den(d3_r),
                     .div_quo(q_hxx), .div_ovf(o_hxx));
  ppq_div u_div_hyy (.clk(clk), .div_num(hyy_num_r), .div_den(d3_r),
                     .div_quo(q_hyy), .div_ovf(o_hyy));
  ppq_div u_div_hxy (.clk(clk), .div_num(hxy_num_r), .div_den(d3_r),
                     .div_quo(q_hxy), .div_ovf(o_hxy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dv_side_r[i] <= '0;
      end
    end else begin
      dv_side_r[0] <= s4_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv_side_r[i] <= dv_side_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturation, inactive and degenerate items
  // --------------------------------------------------------------------------
  function automatic logic [OUT_W-1:0] sat_out(input logic [QUO_W-1:0] quo,
                                               input logic ovf,
                                               input logic neg);
    logic [OUT_W-1:0] mag;
    logic [OUT_W-1:0] res;
    mag = {1'b0, quo[QUO_W-2:0]};
    if (ovf || quo[QUO_W-1]) begin
      res = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      res = neg ? OUT_W'(-mag) : mag;
    end
    return res;
  endfunction

  post_t             post;
  logic              deriv_en;
  logic              out_valid_r, out_active_r, out_degenerate_r;
  logic [COST_W-1:0] out_cost_r;
  logic [OUT_W-1:0]  out_gx_r, out_gy_r, out_hxx_r, out_hyy_r, out_hxy_r;

  assign post     = dv_side_r[DIV_LAT-1];
  assign deriv_en = post.act && !post.zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= post.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_active_r     <= post.act;
    out_degenerate_r <= post.act && post.zero;
    out_cost_r       <= post.act ? post.cost : '0;
    out_gx_r         <= deriv_en ? sat_out(q_gx, o_gx, !post.nx) : '0;
    out_gy_r         <= deriv_en ? sat_out(q_gy, o_gy, !post.ny) : '0;
    out_hxx_r        <= deriv_en ? sat_out(q_hxx, o_hxx, post.hxx_neg) : '0;
    out_hyy_r        <= deriv_en ? sat_out(q_hyy, o_hyy, post.hyy_neg) : '0;
    out_hxy_r        <= deriv_en ? sat_out(q_hxy, o_hxy, post.nx ^ post.ny) : '0;
  end

  assign out_valid      = out_valid_r;
  assign out_active     = out_active_r;
  assign out_degenerate = out_degenerate_r;
  assign out_cost       = out_cost_r;
  assign out_grad_x     = out_gx_r;
  assign out_grad_y     = out_gy_r;
  assign out_hess_xx    = out_hxx_r;
  assign out_hess_yy    = out_hyy_r;
  assign out_hess_xy    = out_hxy_r;

endmodule

`default_nettype wire

// ===== hdl/ppq_mul.sv =====
// ============================================================================
// ppq_mul
// Unsigned 64 x 64 multiplier, three register stages: four 32 x 32 partial
// products, then the cross terms, then the final sum.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppq_mul (
  input  wire logic                        clk,
  input  wire logic [ppq_pkg::OP_W-1:0]    mul_a,
  input  wire logic [ppq_pkg::OP_W-1:0]    mul_b,
  output logic      [ppq_pkg::PROD_W-1:0]  mul_p
);

  localparam int OP_W   = ppq_pkg::OP_W;
  localparam int HALF_W = ppq_pkg::HALF_W;
  localparam int PROD_W = ppq_pkg::PROD_W;

  logic [OP_W-1:0]   pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [OP_W-1:0]   lo_r, hi_r;
  logic [OP_W:0]     mid_r;
  logic [PROD_W-1:0] prod_r;

  // Partial products
  always_ff @(posedge clk) begin
    pp_ll_r <= mul_a[HALF_W-1:0] * mul_b[HALF_W-1:0];
    pp_lh_r <= mul_a[HALF_W-1:0] * mul_b[OP_W-1:HALF_W];
    pp_hl_r <= mul_a[OP_W-1:HALF_W] * mul_b[HALF_W-1:0];
    pp_hh_r <= mul_a[OP_W-1:HALF_W] * mul_b[OP_W-1:HALF_W];
  end

  // Cross terms
  always_ff @(posedge clk) begin
    lo_r  <= pp_ll_r;
    hi_r  <= pp_hh_r;
    mid_r <= {1'b0, pp_lh_r} + {1'b0, pp_hl_r};
  end

  // Final sum
  always_ff @(posedge clk) begin
    prod_r <= {hi_r, lo_r} + {{(HALF_W-1){1'b0}}, mid_r, {HALF_W{1'b0}}};
  end

  assign mul_p = prod_r;

endmodule

`default_nettype wire

// ===== hdl/ppq_sqrt.sv =====
// ============================================================================
// ppq_sqrt
// Pipelined floor square root, digit by digit: four result bits per stage.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppq_sqrt (
  input  wire logic                        clk,
  input  wire logic [ppq_pkg::RAD_W-1:0]   sq_rad,
  output logic      [ppq_pkg::ROOT_W-1:0]  sq_root
);

  localparam int RAD_W  = ppq_pkg::RAD_W;
  localparam int ROOT_W = ppq_pkg::ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SH_W   = REM_W + 2;
  localparam int DPS    = ppq_pkg::SQRT_DPS;
  localparam int LAT    = ppq_pkg::SQRT_LAT;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  sqrt_st_t st_r   [LAT];
  sqrt_st_t st_nxt [LAT];
  sqrt_st_t st_in;

  // One result bit: bring down two radicand bits, try 4q+1
  function automatic sqrt_st_t sqrt_digit(input sqrt_st_t s);
    sqrt_st_t        o;
    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    rem_sh = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial  = SH_W'({s.root, 2'b01});
    o.rad  = {s.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = REM_W'(rem_sh - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sqrt_st_t sqrt_stage(input sqrt_st_t s);
    sqrt_st_t t;
    t = s;
    for (int j = 0; j < DPS; j++) begin
      t = sqrt_digit(t);
    end
    return t;
  endfunction

  assign st_in = '{rad: sq_rad, rem: '0, root: '0};

  // Stage logic
  always_comb begin
    st_nxt[0] = sqrt_stage(st_in);
    for (int k = 1; k < LAT; k++) begin
      st_nxt[k] = sqrt_stage(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LAT; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  assign sq_root = st_r[LAT-1].root;

endmodule

`default_nettype wire

// ===== hdl/ppq_div.sv =====
// ============================================================================
// ppq_div
// Pipelined restoring divider: the first stage flags quotients that do not fit
// the quotient width, then each later stage adds one quotient bit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppq_div (
  input  wire logic                       clk,
  input  wire logic [ppq_pkg::NUM_W-1:0]  div_num,
  input  wire logic [ppq_pkg::DEN_W-1:0]  div_den,
  output logic      [ppq_pkg::QUO_W-1:0]  div_quo,
  output logic                            div_ovf
);

  localparam int NUM_W  = ppq_pkg::NUM_W;
  localparam int DEN_W  = ppq_pkg::DEN_W;
  localparam int QUO_W  = ppq_pkg::QUO_W;
  localparam int LAT    = ppq_pkg::DIV_LAT;
  localparam int HEAD_W = NUM_W - QUO_W;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic             ovf;
  } div_st_t;

  div_st_t          st_r   [LAT];
  div_st_t          st_nxt [LAT];
  logic [DEN_W-1:0] head;

  // One quotient bit
  function automatic div_st_t div_bit(input div_st_t s);
    div_st_t        o;
    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] den_x;
    rem_sh = {s.rem, s.low[QUO_W-1]};
    den_x  = {1'b0, s.den};
    o      = s;
    o.low  = {s.low[QUO_W-2:0], 1'b0};
    if (rem_sh >= den_x) begin
      o.rem = DEN_W'(rem_sh - den_x);
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = rem_sh[DEN_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  assign head = DEN_W'(div_num[NUM_W-1:QUO_W]);

  // Range check, then the bit stages
  always_comb begin
    st_nxt[0].rem = head;
    st_nxt[0].den = div_den;
    st_nxt[0].low = div_num[QUO_W-1:0];
    st_nxt[0].quo = '0;
    st_nxt[0].ovf = (head >= div_den);
    for (int k = 1; k < LAT; k++) begin
      st_nxt[k] = div_bit(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LAT; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  assign div_quo = st_r[LAT-1].quo;
  assign div_ovf = st_r[LAT-1].ovf;

endmodule

`default_nettype wire
